// ----- rtl/core/gpd_pkg.sv -----
// Shared widths, register indexes and stage payload types of the pixel divider.
`default_nettype none

package gpd_pkg;

  localparam int SAMPLE_BITS = 16;

  localparam int EPS_W = 15;
  localparam int FRAC_W = 4;
  localparam int MIN_W = 16;
  localparam int MAX_W = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SHIFT = (2 ** FRAC_W) - 1;
  localparam int QW = SAMPLE_BITS + MAX_SHIFT;
  localparam int BPS = 4;
  localparam int STAGES = (QW + BPS - 1) / BPS;
  localparam int QWP = STAGES * BPS;
  localparam int SW = QWP + 2;
  localparam int CMP_W = SAMPLE_BITS + EPS_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_EPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd3;

  typedef struct packed {
    logic                   guarded;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] dmag;
    logic [SAMPLE_BITS-1:0] rem;
    logic [QWP-1:0]         dvd;
    logic [QWP-1:0]         quo;
  } div_t;

  typedef struct packed {
    logic                 guarded;
    logic signed [SW-1:0] q;
  } rnd_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] quotient;
    logic                   guarded;
    logic                   sat;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpd_prep.sv -----
// Entry stage: operand magnitudes, fraction scaling and the divisor guard.
`default_nettype none

module gpd_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [gpd_pkg::EPS_W-1:0]           eps_i,
  input  logic [gpd_pkg::FRAC_W-1:0]          frac_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [gpd_pkg::SAMPLE_BITS-1:0] numerator_i,
  input  logic signed [gpd_pkg::SAMPLE_BITS-1:0] divisor_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output gpd_pkg::div_t                       data_o
);

  logic                           vld_q;
  gpd_pkg::div_t                  data_q;
  gpd_pkg::div_t                  data_d;
  logic [gpd_pkg::SAMPLE_BITS-1:0] nmag;
  logic [gpd_pkg::SAMPLE_BITS-1:0] dmag;

  always_comb begin
    nmag = numerator_i[gpd_pkg::SAMPLE_BITS-1] ? (~numerator_i + 1'b1) : numerator_i;
    dmag = divisor_i[gpd_pkg::SAMPLE_BITS-1] ? (~divisor_i + 1'b1) : divisor_i;
    data_d.guarded = (gpd_pkg::CMP_W'(dmag) <= gpd_pkg::CMP_W'(eps_i));
    data_d.neg = numerator_i[gpd_pkg::SAMPLE_BITS-1] ^ divisor_i[gpd_pkg::SAMPLE_BITS-1];
    data_d.dmag = dmag;
    data_d.rem = '0;
    data_d.dvd = gpd_pkg::QWP'(nmag) << frac_i;
    data_d.quo = '0;
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/gpd_div_stage.sv -----
// One restoring-division stage that retires four quotient bits.
`default_nettype none

module gpd_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  gpd_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output gpd_pkg::div_t data_o
);

  logic          vld_q;
  gpd_pkg::div_t data_q;
  gpd_pkg::div_t data_d;

  always_comb begin
    logic [gpd_pkg::SAMPLE_BITS:0] trial;
    data_d = data_i;
    for (int b = 0; b < gpd_pkg::BPS; b++) begin
      trial = {data_d.rem, data_d.dvd[gpd_pkg::QWP-1]};
      data_d.dvd = {data_d.dvd[gpd_pkg::QWP-2:0], 1'b0};
      if (trial >= {1'b0, data_d.dmag}) begin
        trial = trial - {1'b0, data_d.dmag};
        data_d.quo = {data_d.quo[gpd_pkg::QWP-2:0], 1'b1};
      end else begin
        data_d.quo = {data_d.quo[gpd_pkg::QWP-2:0], 1'b0};
      end
      data_d.rem = trial[gpd_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/gpd_post.sv -----
// Rounding to nearest even, sign restore, guard zeroing, limit clipping and the output register.
`default_nettype none

module gpd_post (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [gpd_pkg::SW-1:0]       lim_lo_i,
  input  logic signed [gpd_pkg::SW-1:0]       lim_hi_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  gpd_pkg::div_t                       data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output gpd_pkg::res_t                       data_o
);

  logic                              rnd_vld_q;
  gpd_pkg::rnd_t                     rnd_q;
  gpd_pkg::rnd_t                     rnd_d;
  logic                              out_vld_q;
  gpd_pkg::res_t                     out_q;
  gpd_pkg::res_t                     out_d;
  logic                              rnd_rdy;
  logic                              inc;
  logic [gpd_pkg::SAMPLE_BITS:0]     two_r;
  logic [gpd_pkg::QWP:0]             qm;
  logic signed [gpd_pkg::SW-1:0]     q_mag;
  logic signed [gpd_pkg::SW-1:0]     q_clip;

  always_comb begin
    two_r = {data_i.rem, 1'b0};
    inc = (two_r > {1'b0, data_i.dmag}) ||
          ((two_r == {1'b0, data_i.dmag}) && data_i.quo[0]);
    qm = {1'b0, data_i.quo} + (gpd_pkg::QWP + 1)'(inc);
    q_mag = $signed({1'b0, qm});
    rnd_d.guarded = data_i.guarded;
    rnd_d.q = data_i.neg ? -q_mag : q_mag;
  end

  always_comb begin
    out_d.guarded = rnd_q.guarded;
    out_d.sat = 1'b0;
    q_clip = rnd_q.q;
    if (rnd_q.guarded) begin
      q_clip = '0;
    end else if (rnd_q.q > lim_hi_i) begin
      q_clip = lim_hi_i;
      out_d.sat = 1'b1;
    end else if (rnd_q.q < lim_lo_i) begin
      q_clip = lim_lo_i;
      out_d.sat = 1'b1;
    end
    out_d.quotient = q_clip[gpd_pkg::SAMPLE_BITS-1:0];
  end

  assign rnd_rdy = !out_vld_q || ready_i;
  assign ready_o = !rnd_vld_q || rnd_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (ready_o) begin
        rnd_vld_q <= valid_i;
      end
      if (rnd_rdy) begin
        out_vld_q <= rnd_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rnd_q <= rnd_d;
    end
    if (rnd_vld_q && rnd_rdy) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/guarded_pixel_divide.sv -----
// Top level of the guarded fixed-point pixel divider.
// One entry register, eight divider stages of four quotient bits each, a rounding register
// and the output register. Throughput is one transaction per cycle with no bubbles while
// out_ready_i is held high. Reset clears all valid bits and loads the registers with
// eps 0, frac 0, min 0, max 255.
`default_nettype none

module guarded_pixel_divide (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [gpd_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [gpd_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [gpd_pkg::SAMPLE_BITS-1:0] numerator_i,
  input  logic signed [gpd_pkg::SAMPLE_BITS-1:0] divisor_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [gpd_pkg::SAMPLE_BITS-1:0] quotient_o,
  output logic                                   divisor_small_o,
  output logic                                   saturated_o
);

  logic [gpd_pkg::EPS_W-1:0]        eps_q;
  logic [gpd_pkg::FRAC_W-1:0]       frac_q;
  logic signed [gpd_pkg::MIN_W-1:0] out_min_q;
  logic [gpd_pkg::MAX_W-1:0]        out_max_q;
  logic signed [gpd_pkg::SW-1:0]    lim_lo;
  logic signed [gpd_pkg::SW-1:0]    lim_hi;
  logic [gpd_pkg::SAMPLE_BITS-1:0]  lim_lo_n;
  logic [gpd_pkg::SAMPLE_BITS-1:0]  lim_hi_n;

  logic                 stg_vld [0:gpd_pkg::STAGES];
  logic                 stg_rdy [0:gpd_pkg::STAGES];
  gpd_pkg::div_t        stg_bus [0:gpd_pkg::STAGES];
  gpd_pkg::res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
      frac_q <= '0;
      out_min_q <= '0;
      out_max_q <= gpd_pkg::MAX_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gpd_pkg::CFG_EPS:  eps_q <= cfg_data_i[gpd_pkg::EPS_W-1:0];
        gpd_pkg::CFG_FRAC: frac_q <= cfg_data_i[gpd_pkg::FRAC_W-1:0];
        gpd_pkg::CFG_MIN:  out_min_q <= cfg_data_i[gpd_pkg::MIN_W-1:0];
        gpd_pkg::CFG_MAX:  out_max_q <= cfg_data_i[gpd_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  assign lim_lo = gpd_pkg::SW'(out_min_q);
  assign lim_hi = $signed(gpd_pkg::SW'(out_max_q));
  assign lim_lo_n = lim_lo[gpd_pkg::SAMPLE_BITS-1:0];
  assign lim_hi_n = lim_hi[gpd_pkg::SAMPLE_BITS-1:0];

  gpd_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eps_i       (eps_q),
    .frac_i      (frac_q),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .numerator_i (numerator_i),
    .divisor_i   (divisor_i),
    .valid_o     (stg_vld[0]),
    .ready_i     (stg_rdy[0]),
    .data_o      (stg_bus[0])
  );

  for (genvar k = 0; k < gpd_pkg::STAGES; k++) begin : g_div
    gpd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[k]),
      .ready_o (stg_rdy[k]),
      .data_i  (stg_bus[k]),
      .valid_o (stg_vld[k+1]),
      .ready_i (stg_rdy[k+1]),
      .data_o  (stg_bus[k+1])
    );
  end

  gpd_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .lim_lo_i (lim_lo),
    .lim_hi_i (lim_hi),
    .valid_i  (stg_vld[gpd_pkg::STAGES]),
    .ready_o  (stg_rdy[gpd_pkg::STAGES]),
    .data_i   (stg_bus[gpd_pkg::STAGES]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (res)
  );

  assign quotient_o = res.quotient;
  assign divisor_small_o = res.guarded;
  assign saturated_o = res.sat;

  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divisor_small_o |-> quotient_o == '0 && !saturated_o)
    else $error("Guarded result is not zero or is flagged as saturated.");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> quotient_o == lim_hi_n || quotient_o == lim_lo_n)
    else $error("Saturated result does not equal a limit.");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input is blocked while the pipeline can still advance.");

endmodule

`default_nettype wire
